// ----- src/alfl_pkg.sv -----
// Shared constants and types for the additive lagged Fibonacci generator.
// Used by alfl_ring and additive_lagged_fibonacci_luxury_top; depends on nothing.

package alfl_pkg;

  localparam int LONG_LAG    = 100;
  localparam int SHORT_LAG   = 37;
  localparam int BLOCK_TOTAL = 1009;

  localparam int IDX_W  = $clog2(LONG_LAG);
  localparam int WORD_W = 32;

  // Start of the short tap, relative to the long tap at the start of a run
  localparam int SHORT_START = (LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG;

  localparam int SILENT_STEPS = (BLOCK_TOTAL > LONG_LAG) ? (BLOCK_TOTAL - LONG_LAG) : 0;
  localparam int SILENT_W     = (SILENT_STEPS > 1) ? $clog2(SILENT_STEPS) : 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } ring_wr_t;

endpackage

// ----- src/additive_lagged_fibonacci_luxury_top.sv -----
// Additive lagged Fibonacci generator (lags 100/37, mod 2^32) with luxury decimation.
// Depends on alfl_pkg and alfl_ring.
//
// Usage:
//   Input channel (in_valid/in_ready): in_op selects a load (seed word into ring
//   position in_seed_index; positions past the ring are ignored) or a next step.
//   The first load after reset or after a next word restarts the run: long tap 0,
//   short tap 63, output count 0. Load the whole ring before asking for words.
//   Output channel (out_valid/out_ready): one out_random_word per next word.
// Timing:
//   A load writes the ring from S_IDLE; in_ready stays high for back-to-back loads.
//   A next word goes from acceptance to out_valid through S_FETCH, a ring read,
//   then S_STEP, the add and write-back; in_ready stays low until that step and
//   any silent steps are done, so no new word is taken while one is in flight.
//   The ring memory does one step per cycle while not stalled, so after every
//   100th output 909 silent steps follow, one per cycle, with in_ready low.
// Reset: synchronous, returns to idle, sets the taps to 0 and 63, clears count,
//   silent count and valid flag, sets the run flag. Ring contents are not cleared.
// Stall: a finished word waits in the output register; the next word's add
//   holds until that register is free, so no word is lost or repeated.

module additive_lagged_fibonacci_luxury_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [6:0]  in_seed_index,
  input  logic [31:0] in_seed_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_word
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_FETCH  = 4'b0010,
    S_STEP   = 4'b0100,
    S_SILENT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  alfl_pkg::idx_t  long_r, long_nxt;
  alfl_pkg::idx_t  short_r, short_nxt;
  alfl_pkg::idx_t  count_r, count_nxt;
  logic [alfl_pkg::SILENT_W-1:0] silent_r, silent_nxt;
  logic            loading_r, loading_nxt;
  logic            out_valid_r, out_valid_nxt;
  alfl_pkg::word_t out_word_r, out_word_nxt;

  alfl_pkg::ring_wr_t ring_wr;
  alfl_pkg::idx_t     rd_addr_a, rd_addr_b;
  alfl_pkg::word_t    rd_data_a, rd_data_b;
  alfl_pkg::word_t    sum;
  alfl_pkg::idx_t     long_adv, short_adv;

  logic in_fire;
  logic out_free;
  logic step_fire;

  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;
  assign out_free        = !out_valid_r || out_ready;

  assign step_fire = ((state_r == S_STEP) && out_free) || (state_r == S_SILENT);
  assign sum       = rd_data_a + rd_data_b;

  assign long_adv  = (long_r == alfl_pkg::idx_t'(alfl_pkg::LONG_LAG - 1)) ?
                     '0 : long_r + alfl_pkg::idx_t'(1);
  assign short_adv = (short_r == alfl_pkg::idx_t'(alfl_pkg::LONG_LAG - 1)) ?
                     '0 : short_r + alfl_pkg::idx_t'(1);

  // Read the taps of the following step while this step writes back
  assign rd_addr_a = step_fire ? long_adv : long_r;
  assign rd_addr_b = step_fire ? short_adv : short_r;

  always_comb begin
    ring_wr.en   = 1'b0;
    ring_wr.addr = long_r;
    ring_wr.data = sum;
    if (step_fire) begin
      ring_wr.en = 1'b1;
    end else if (in_fire && (in_op == alfl_pkg::OP_LOAD) &&
                 (in_seed_index < 7'(alfl_pkg::LONG_LAG))) begin
      ring_wr.en   = 1'b1;
      ring_wr.addr = alfl_pkg::idx_t'(in_seed_index);
      ring_wr.data = in_seed_word;
    end
  end

  alfl_ring u_ring (
    .clk       (clk),
    .wr        (ring_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_comb begin
    state_nxt     = state_r;
    long_nxt      = long_r;
    short_nxt     = short_r;
    count_nxt     = count_r;
    silent_nxt    = silent_r;
    loading_nxt   = loading_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;

    if (step_fire) begin
      long_nxt  = long_adv;
      short_nxt = short_adv;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == alfl_pkg::OP_LOAD) begin
            if (loading_r) begin
              long_nxt    = '0;
              short_nxt   = alfl_pkg::idx_t'(alfl_pkg::SHORT_START);
              count_nxt   = '0;
              loading_nxt = 1'b0;
            end
          end else begin
            loading_nxt = 1'b1;
            state_nxt   = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = sum;
          if (count_r == alfl_pkg::idx_t'(alfl_pkg::LONG_LAG - 1)) begin
            count_nxt = '0;
            if (alfl_pkg::SILENT_STEPS > 0) begin
              silent_nxt = alfl_pkg::SILENT_W'(alfl_pkg::SILENT_STEPS - 1);
              state_nxt  = S_SILENT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            count_nxt = count_r + alfl_pkg::idx_t'(1);
            state_nxt = S_IDLE;
          end
        end
      end
      S_SILENT: begin
        silent_nxt = silent_r - alfl_pkg::SILENT_W'(1);
        if (silent_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      long_r      <= '0;
      short_r     <= alfl_pkg::idx_t'(alfl_pkg::SHORT_START);
      count_r     <= '0;
      silent_r    <= '0;
      loading_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      long_r      <= long_nxt;
      short_r     <= short_nxt;
      count_r     <= count_nxt;
      silent_r    <= silent_nxt;
      loading_r   <= loading_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTHESIS
  // The short tap always trails the long tap by the fixed lag
  a_tap_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, long_r} + {1'b0, alfl_pkg::idx_t'(alfl_pkg::SHORT_START)}) ==
     {1'b0, short_r}) ||
    (({1'b0, long_r} + {1'b0, alfl_pkg::idx_t'(alfl_pkg::SHORT_START)}) ==
     ({1'b0, short_r} + {1'b0, alfl_pkg::idx_t'(alfl_pkg::LONG_LAG)})))
    else $error("short tap lost its spacing from the long tap");

  a_taps_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (long_r < alfl_pkg::idx_t'(alfl_pkg::LONG_LAG)) &&
    (short_r < alfl_pkg::idx_t'(alfl_pkg::LONG_LAG)))
    else $error("ring tap out of range");

  a_word_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_STEP))
    else $error("output word appeared outside a visible step");

  a_silent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SILENT) |-> !in_ready)
    else $error("input accepted during silent steps");
`endif

endmodule

// ----- src/alfl_ring.sv -----
// Lag ring: one write port, two registered read ports, with write-to-read bypass.
// Depends on alfl_pkg.

module alfl_ring (
  input  logic             clk,
  input  alfl_pkg::ring_wr_t wr,
  input  alfl_pkg::idx_t   rd_addr_a,
  input  alfl_pkg::idx_t   rd_addr_b,
  output alfl_pkg::word_t  rd_data_a,
  output alfl_pkg::word_t  rd_data_b
);

  alfl_pkg::word_t mem [alfl_pkg::LONG_LAG];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Forward a same-cycle write so the next step never sees stale data
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr_a)) begin
      rd_data_a <= wr.data;
    end else begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (wr.en && (wr.addr == rd_addr_b)) begin
      rd_data_b <= wr.data;
    end else begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the lagged Fibonacci generator with luxury decimation.
// Seeds the ring, asks for words, and checks each one against an in-bench predictor.
// Depends on alfl_pkg and additive_lagged_fibonacci_luxury_top.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 340;
  localparam int IDLE_LIMIT   = 4 * (alfl_pkg::SILENT_STEPS + 100);
  localparam int MAX_PRINTED  = 40;

  typedef struct {
    logic            op;
    alfl_pkg::idx_t  index;
    alfl_pkg::word_t word;
    bit              drain_first;
  } in_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = alfl_pkg::OP_LOAD;
  logic [6:0]  in_seed_index = '0;
  logic [31:0] in_seed_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_random_word;

  in_word_t        pending_words[$];
  alfl_pkg::word_t expected_randoms[$];

  // predictor state
  alfl_pkg::word_t ring_model[alfl_pkg::LONG_LAG];
  int unsigned tap_long = 0;
  int unsigned tap_short = alfl_pkg::SHORT_START;
  int unsigned emitted_in_block = 0;
  bit          run_open = 1'b1;

  int          words_predicted = 0;
  int          words_received = 0;
  int          mismatches = 0;
  int          planned_items = 0;
  int          load_count = 0;
  int          ignored_loads = 0;
  int          next_count = 0;
  int          luxury_skips = 0;
  int          drain_pauses = 0;
  int          idle_cycles = 0;

  additive_lagged_fibonacci_luxury_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_seed_index   (in_seed_index),
    .in_seed_word    (in_seed_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $realtime, msg);
    end
  endtask

  function automatic alfl_pkg::word_t lagged_sum_step();
    alfl_pkg::word_t sum;
    sum = ring_model[tap_long] + ring_model[tap_short];
    ring_model[tap_long] = sum;
    tap_long = (tap_long + 1) % alfl_pkg::LONG_LAG;
    tap_short = (tap_short + 1) % alfl_pkg::LONG_LAG;
    return sum;
  endfunction

  // Apply one accepted word to the predictor; returns 1 when it yields a random word.
  function automatic bit apply_in_word(input in_word_t w, output alfl_pkg::word_t rnd);
    rnd = '0;
    if (w.op == alfl_pkg::OP_LOAD) begin
      if (run_open) begin
        tap_long = 0;
        tap_short = alfl_pkg::SHORT_START;
        emitted_in_block = 0;
        run_open = 1'b0;
      end
      if (w.index < alfl_pkg::LONG_LAG) ring_model[w.index] = w.word;
      return 1'b0;
    end
    run_open = 1'b1;
    rnd = lagged_sum_step();
    emitted_in_block++;
    if (emitted_in_block >= alfl_pkg::LONG_LAG) begin
      for (int k = 0; k < alfl_pkg::SILENT_STEPS; k++) void'(lagged_sum_step());
      emitted_in_block = 0;
      luxury_skips++;
    end
    return 1'b1;
  endfunction

  function automatic alfl_pkg::word_t pick_seed_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(input int index, input alfl_pkg::word_t word, input bit drain);
    in_word_t w;
    w.op = alfl_pkg::OP_LOAD;
    w.index = alfl_pkg::idx_t'(index);
    w.word = word;
    w.drain_first = drain;
    pending_words.push_back(w);
    planned_items++;
  endtask

  task automatic push_next(input bit drain);
    in_word_t w;
    w.op = alfl_pkg::OP_NEXT;
    // index and word are don't-care on a next; fill them with noise
    w.index = alfl_pkg::idx_t'($urandom_range(0, 127));
    w.word = $urandom;
    w.drain_first = drain;
    pending_words.push_back(w);
    planned_items++;
  endtask

  // Write every ring entry once in shuffled order, with stray out-of-range loads mixed in.
  task automatic push_full_seed(input bit drain);
    int order[alfl_pkg::LONG_LAG];
    int j;
    int t;
    for (int i = 0; i < alfl_pkg::LONG_LAG; i++) order[i] = i;
    for (int i = alfl_pkg::LONG_LAG - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < alfl_pkg::LONG_LAG; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_load($urandom_range(alfl_pkg::LONG_LAG, 127), $urandom, drain && i == 0);
      end
      push_load(order[i], pick_seed_word(), drain && i == 0);
    end
  endtask

  // Driver: present pending words, predict on acceptance.
  int              in_gap;
  bit              in_burst = 1'b0;
  in_word_t        in_flight;
  alfl_pkg::word_t predicted_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = $urandom_range(0, 9);
    end else begin
      if (in_valid && in_ready) begin
        if (in_flight.op == alfl_pkg::OP_LOAD) begin
          load_count++;
          if (in_flight.index >= alfl_pkg::LONG_LAG) ignored_loads++;
        end else begin
          next_count++;
        end
        if (apply_in_word(in_flight, predicted_word)) begin
          expected_randoms.push_back(predicted_word);
          words_predicted++;
        end
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (pending_words.size() != 0 &&
                     (!pending_words[0].drain_first || words_predicted == words_received)) begin
          in_flight = pending_words.pop_front();
          if (in_flight.drain_first) drain_pauses++;
          in_valid <= 1'b1;
          in_op <= in_flight.op;
          in_seed_index <= in_flight.index;
          in_seed_word <= in_flight.word;
          if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each word with the oldest prediction.
  int              out_gap;
  bit              out_burst = 1'b0;
  bit              out_taken;
  alfl_pkg::word_t expected_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = $urandom_range(0, 9);
    end else begin
      out_taken = out_valid && out_ready;
      if (out_taken) begin
        if (expected_randoms.size() == 0) begin
          report_mismatch($sformatf("unexpected random_word %h", out_random_word));
        end else begin
          expected_word = expected_randoms.pop_front();
          if (out_random_word !== expected_word) begin
            report_mismatch($sformatf("random_word %h, expected %h (word %0d)",
                                      out_random_word, expected_word, words_received));
          end
        end
        words_received <= words_received + 1;
        if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
        out_gap = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (!out_ready || out_taken) begin
        if (out_gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          out_gap--;
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", idle_cycles);
        $display("testbench NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int random_base;
    int sel;
    int n;
    bit first_long;

    // The ring is undefined after reset: seed all of it before any next.
    push_full_seed(1'b0);

    // Directed: field extremes, wrap of the sum, ignored indices, run restarts.
    push_load(0, '0, 1'b1);
    push_load(99, '1, 1'b0);
    push_load(127, 32'hA5A5_A5A5, 1'b0);
    push_load(alfl_pkg::LONG_LAG, '1, 1'b0);
    push_load(63, '1, 1'b0);
    push_load(1, '1, 1'b0);
    push_load(64, 32'h0000_0001, 1'b0);
    repeat (4) push_next(1'b0);
    push_load(127, 32'h1234_5678, 1'b0);
    repeat (3) push_next(1'b0);
    push_load(50, 32'h8000_0000, 1'b0);
    push_load(50, 32'h7FFF_FFFF, 1'b0);
    push_next(1'b1);
    push_next(1'b0);

    random_base = planned_items;
    first_long = 1'b1;
    while (planned_items - random_base < RANDOM_ITEMS) begin
      sel = first_long ? 0 : $urandom_range(0, 11);
      first_long = 1'b0;
      case (sel)
        0: begin
          // long run: crosses the 100-word boundary into the silent steps
          n = $urandom_range(100, 160);
          push_next($urandom_range(0, 3) == 0);
          repeat (n - 1) push_next(1'b0);
        end
        1: begin
          push_full_seed($urandom_range(0, 3) == 0);
          repeat ($urandom_range(1, 30)) push_next(1'b0);
        end
        2: begin
          repeat ($urandom_range(1, 10)) push_next($urandom_range(0, 7) == 0);
        end
        default: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
              push_load($urandom_range(alfl_pkg::LONG_LAG, 127), $urandom,
                        i == 0 && $urandom_range(0, 3) == 0);
            end else begin
              push_load($urandom_range(0, alfl_pkg::LONG_LAG - 1), pick_seed_word(),
                        i == 0 && $urandom_range(0, 3) == 0);
            end
          end
          repeat ($urandom_range(1, 40)) push_next(1'b0);
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (words_received != words_predicted) @(posedge clk);
    // hold long enough for a silent pass and any stray word
    repeat (alfl_pkg::SILENT_STEPS + 50) @(posedge clk);

    if (expected_randoms.size() != 0) begin
      report_mismatch($sformatf("%0d random words never arrived", expected_randoms.size()));
    end

    $display("covered %0d seed loads (%0d outside the ring) and %0d next requests",
             load_count, ignored_loads, next_count);
    $display("checked %0d random words across %0d luxury skips, %0d drained pauses",
             words_received, luxury_skips, drain_pauses);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
